>>> src/lnto_pkg.sv
// shared types, constants and register codes for the node liveness timeout monitor
package lnto_pkg;

  localparam int NODE_COUNT = 16;
  localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int MAP_BITS   = 16;
  localparam int MAP_N      = (NODE_COUNT < MAP_BITS) ? NODE_COUNT : MAP_BITS;

  localparam int TIME_W = 32;
  localparam int ADDR_W = 8;
  localparam int PADDR_W = 3;

  localparam logic [ADDR_W-1:0] ACCEPTED_PROTOCOL = 8'h01;
  localparam logic [TIME_W-1:0] RESET_TIMEOUT     = 32'd5000;
  localparam logic [TIME_W-1:0] RESET_INTERVAL    = 32'd1000;

  // opcode values
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_OFFLINE_TIMEOUT = 1'b0;
  localparam logic REG_SWEEP_INTERVAL  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] node_addr;
    logic [ADDR_W-1:0] protocol_num;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [MAP_BITS-1:0] online_map;
    logic                frame_recorded;
    logic                sweep_done;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] offline_timeout;
    logic [TIME_W-1:0] sweep_interval;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

>>> src/lnto_age_cmp.sv
// shared modulo-2^32 age compare: (now - then) >= limit
module lnto_age_cmp
  import lnto_pkg::*;
(
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] then_time,
  input  logic [TIME_W-1:0] limit,
  output logic              reached
);

  logic [TIME_W-1:0] age;

  assign age     = now - then_time;
  assign reached = (age >= limit);

endmodule

>>> src/lnto_regs.sv
// apb configuration registers
module lnto_regs
  import lnto_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offline_timeout <= RESET_TIMEOUT;
      cfg.sweep_interval  <= RESET_INTERVAL;
    end else if (wr_en) begin
      case (paddr[2])
        REG_OFFLINE_TIMEOUT: cfg.offline_timeout <= pwdata;
        REG_SWEEP_INTERVAL:  cfg.sweep_interval  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OFFLINE_TIMEOUT: prdata = cfg.offline_timeout;
      REG_SWEEP_INTERVAL:  prdata = cfg.sweep_interval;
      default:             prdata = '0;
    endcase
  end

endmodule

>>> src/lnto_core.sv
// liveness state and the sweep sequencer around the shared age compare
module lnto_core
  import lnto_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       start,
  input  in_item_t   item,
  input  logic       res_take,
  output core_stat_t stat,
  output out_item_t  res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  state_t                  state;
  in_item_t                item_q;
  logic                    recorded;
  logic                    swept;
  logic [IDX_W-1:0]        scan_idx;
  logic [NODE_COUNT-1:0]   online;
  logic [TIME_W-1:0]       last_seen [NODE_COUNT];
  logic [TIME_W-1:0]       last_sweep;

  logic                    frame_ok;
  logic [IDX_W-1:0]        frame_idx;
  logic [TIME_W-1:0]       cmp_then;
  logic [TIME_W-1:0]       cmp_limit;
  logic                    cmp_ge;

  assign frame_ok  = (item.opcode == OP_FRAME) && (item.protocol_num == ACCEPTED_PROTOCOL)
                     && (item.node_addr != '0)
                     && (item.node_addr <= ADDR_W'(NODE_COUNT));
  assign frame_idx = IDX_W'(item.node_addr - ADDR_W'(1));

  // one compare unit: interval check first, then one node per cycle
  assign cmp_then  = (state == S_CHECK) ? last_sweep : last_seen[scan_idx];
  assign cmp_limit = (state == S_CHECK) ? cfg.sweep_interval : cfg.offline_timeout;

  lnto_age_cmp u_cmp (
    .now       (item_q.now),
    .then_time (cmp_then),
    .limit     (cmp_limit),
    .reached   (cmp_ge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      online     <= '0;
      last_sweep <= '0;
      scan_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (item.opcode == OP_FRAME) begin
              if (frame_ok) begin
                online[frame_idx] <= 1'b1;
              end
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (cmp_ge) begin
            last_sweep <= item_q.now;
            scan_idx   <= '0;
            state      <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (online[scan_idx] && cmp_ge) begin
            online[scan_idx] <= 1'b0;
          end
          if (scan_idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: item copy, flags and last-seen times
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item_q   <= item;
      recorded <= frame_ok;
      swept    <= 1'b0;
      if (frame_ok) begin
        last_seen[frame_idx] <= item.now;
      end
    end else if (state == S_CHECK && cmp_ge) begin
      swept <= 1'b1;
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  assign res.online_map     = MAP_BITS'(online[MAP_N-1:0]);
  assign res.frame_recorded = recorded;
  assign res.sweep_done     = swept;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !(recorded && swept))
    else $error("frame and sweep flags both set");

  a_sweep_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && cmp_ge) |=> (last_sweep == $past(item_q.now)))
    else $error("sweep time not recorded");

  a_scan_no_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> ((online & ~$past(online)) == '0))
    else $error("sweep brought a node online");

  a_poll_no_record: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |=> !recorded)
    else $error("poll marked a frame recorded");

endmodule

>>> src/node_liveness_timeout_monitor_top.sv
// top level: item and result channels, result register, config port
//
// tracks the liveness of NODE_COUNT bus nodes (addresses 1..NODE_COUNT). a frame
// transfer with protocol number 1 and a valid node address stamps that node's
// last-seen time and marks it online; broadcast, out-of-range addresses and other
// protocols are ignored. a poll transfer runs a timeout sweep when at least
// sweep_interval ticks have passed since the last sweep (all ages modulo 2^32);
// the sweep marks offline each online node whose age has reached offline_timeout.
// every item gives exactly one result with the online map of nodes 1..16.
// steps: a frame goes from idle straight to done; a poll goes through the interval
// check and, when a sweep runs, then through a scan of every node, since one shared
// age subtract-and-compare unit checks the interval and then one node per cycle.
// one item is in work at a time; item_ready is high while the sequencer is idle.
// the result sits in an output register, so a waiting result does not hold back
// the next item's work. registers: offline_timeout at 0x0 (reset 5000),
// sweep_interval at 0x4 (reset 1000); write them only while the block is idle.
module node_liveness_timeout_monitor_top
  import lnto_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // item channel
  input  logic               item_valid,
  output logic               item_ready,
  input  in_item_t           item,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result
);

  cfg_t       cfg;
  core_stat_t stat;
  out_item_t  core_res;
  logic       start;
  logic       slot_free;

  lnto_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // transfer in only when the sequencer is idle
  assign item_ready = stat.idle;
  assign start      = item_valid && item_ready;

  // output register is free when empty or being drained this cycle
  assign slot_free = !result_valid || result_ready;

  lnto_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .item     (item),
    .res_take (slot_free),
    .stat     (stat),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stat.done && slot_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload, loaded when the core hands over
  always_ff @(posedge clk) begin
    if (stat.done && slot_free) begin
      result <= core_res;
    end
  end

endmodule
